// File: rtl/sedh_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers for the serpentine error diffusion halftoner.
// No dependencies; every other file but sedh_ram takes names from here as sedh_pkg::name.
package sedh_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int ERROR_BITS = 14;

    localparam int COL_BITS   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_BITS   = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int BANK_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int BANK_ABITS = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int LANES      = 3;
    localparam int LINE_BITS  = LANES * ERROR_BITS;
    localparam int WIDE_BITS  = ERROR_BITS + 3;

    localparam int FULL_ON = 4080;
    localparam int ERR_MAX = (1 << (ERROR_BITS - 1)) - 1;
    localparam int ERR_MIN = -ERR_MAX - 1;

    localparam int SAMPLE_BITS     = 8;
    localparam int THR_BITS        = 8;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int CFG_DATA_BITS   = 13;
    localparam int CFG_INDEX_BITS  = 2;

    localparam logic [THR_BITS-1:0]        THRESHOLD_RESET = 8'd128;
    localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET     = 11'd640;
    localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET    = 13'd426;

    // Floyd-Steinberg weights, in sixteenths
    localparam logic [2:0] W_AHEAD  = 3'd7;
    localparam logic [2:0] W_BELOW  = 3'd5;
    localparam logic [2:0] W_BEHIND = 3'd3;
    localparam logic [2:0] W_DIAG   = 3'd1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_WIDTH     = 2'd1,
        REG_HEIGHT    = 2'd2
    } cfg_reg_t;

    typedef logic [COL_BITS-1:0]          col_t;
    typedef logic [ROW_BITS-1:0]          row_t;
    typedef logic signed [ERROR_BITS-1:0] err_t;
    typedef logic signed [WIDE_BITS-1:0]  wide_t;
    typedef logic [BANK_ABITS-1:0]        bank_addr_t;
    typedef logic [LINE_BITS-1:0]         line_t;

    typedef struct packed {
        col_t c;
        col_t behind;
        logic first;
        logic last_col;
        logic last_row;
    } pos_t;

    typedef struct packed {
        logic fire;
        logic last_col;
        logic last_row;
    } lane_ctl_t;

    function automatic err_t sat(input wide_t x);
        err_t r;
        if (x > wide_t'(ERR_MAX))
            r = err_t'(ERR_MAX);
        else if (x < wide_t'(ERR_MIN))
            r = err_t'(ERR_MIN);
        else
            r = err_t'(x);
        return r;
    endfunction

    // floor((e*w + 8) / 16): round half up
    function automatic err_t share(input err_t e, input logic [2:0] w);
        wide_t x;
        wide_t p;
        wide_t q;
        x = wide_t'(e);
        p = x * wide_t'(w);
        q = (p + wide_t'(8)) >>> 4;
        return err_t'(q);
    endfunction

endpackage

// File: rtl/sedh_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixel requests and halftone results.
// Depends on sedh_pkg for field widths.
interface sedh_pix_if;
    logic                             valid;
    logic                             ready;
    logic [sedh_pkg::SAMPLE_BITS-1:0] red_in;
    logic [sedh_pkg::SAMPLE_BITS-1:0] green_in;
    logic [sedh_pkg::SAMPLE_BITS-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface sedh_res_if;
    logic valid;
    logic ready;
    logic red_on;
    logic green_on;
    logic blue_on;
    logic end_of_row;
    logic end_of_frame;

    modport source (output valid, output red_on, output green_on, output blue_on,
                    output end_of_row, output end_of_frame, input ready);
    modport sink   (input valid, input red_on, input green_on, input blue_on,
                    input end_of_row, input end_of_frame, output ready);
endinterface

// File: rtl/serpentine_error_diffusion_halftone.sv
`timescale 1ns / 1ps
// Top level: config registers, scan, line banks, three color lanes and result register.
// Depends on sedh_pkg, sedh_if, sedh_ram, sedh_scan and sedh_lane.
//
// Channel  Dir  Handshake          Payload
// pixel    in   valid / ready      red_in, green_in, blue_in (8 bits each)
// result   out  valid / ready      red_on, green_on, blue_on, end_of_row, end_of_frame
// config   in   cfg_write strobe   cfg_index (2 bits), cfg_data (13 bits)
//
// One pixel per clock sustained while the result is taken; an accepted request is registered
// with its line bank read, then the lane compute goes into the result register.
// The rate is set by the same-row error loop through each lane: one pixel per cycle.
// After reset a clearing pass zeroes all BANK_DEPTH (512) entries of the line banks, ready low.
// A stalled result holds the compute stage; a new request enters when that stage moves on.
module serpentine_error_diffusion_halftone (
    input  logic                                clk,
    input  logic                                rst_n,
    sedh_pix_if.sink                            pixel,
    sedh_res_if.source                          result,
    input  logic                                cfg_write,
    input  logic [sedh_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sedh_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int EB = sedh_pkg::ERROR_BITS;

    // configuration
    logic [sedh_pkg::THR_BITS-1:0]        thr_reg;
    logic [sedh_pkg::WIDTH_REG_BITS-1:0]  width_reg;
    logic [sedh_pkg::HEIGHT_REG_BITS-1:0] height_reg;

    // clearing pass
    logic                 clr_busy_reg;
    logic                 clr_busy_next;
    sedh_pkg::bank_addr_t clr_idx_reg;
    sedh_pkg::bank_addr_t clr_idx_next;

    // compute stage
    logic                             b_valid_reg;
    logic                             b_valid_next;
    sedh_pkg::pos_t                   b_pos_reg;
    logic [sedh_pkg::SAMPLE_BITS-1:0] b_sample_reg [sedh_pkg::LANES];
    logic                             fwd_hit_reg;
    logic                             fwd_hit_next;
    sedh_pkg::line_t                  fwd_word_reg;
    sedh_pkg::line_t                  fwd_word_next;

    // result register
    logic                       res_valid_reg;
    logic                       res_valid_next;
    logic [sedh_pkg::LANES-1:0] res_on_reg;
    logic                       res_eor_reg;
    logic                       res_eof_reg;

    logic                       accept;
    logic                       b_fire;
    logic                       behind_en;
    sedh_pkg::pos_t             pos;
    sedh_pkg::lane_ctl_t        lane_ctl;
    logic [sedh_pkg::LANES-1:0] lane_on;
    sedh_pkg::line_t            line_word;
    sedh_pkg::line_t            here_word;
    sedh_pkg::line_t            behind_word;

    logic [1:0]           bank_we;
    sedh_pkg::bank_addr_t bank_waddr [2];
    sedh_pkg::line_t      bank_wdata [2];
    sedh_pkg::bank_addr_t bank_raddr;
    sedh_pkg::line_t      bank_rdata [2];

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= sedh_pkg::THRESHOLD_RESET;
            width_reg  <= sedh_pkg::WIDTH_RESET;
            height_reg <= sedh_pkg::HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sedh_pkg::REG_THRESHOLD: thr_reg    <= cfg_data[sedh_pkg::THR_BITS-1:0];
                sedh_pkg::REG_WIDTH:     width_reg  <= cfg_data[sedh_pkg::WIDTH_REG_BITS-1:0];
                sedh_pkg::REG_HEIGHT:    height_reg <= cfg_data[sedh_pkg::HEIGHT_REG_BITS-1:0];
                default:                 ;
            endcase
        end
    end

    // ---------------------------------------------------------------- handshake
    assign b_fire      = b_valid_reg && (!res_valid_reg || result.ready);
    assign pixel.ready = !clr_busy_reg && (!b_valid_reg || b_fire);
    assign accept      = pixel.valid && pixel.ready;
    assign behind_en   = !b_pos_reg.first && !b_pos_reg.last_row;

    sedh_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (accept),
        .image_width  (width_reg),
        .image_height (height_reg),
        .pos          (pos)
    );

    // ---------------------------------------------------------------- line banks
    // even columns in bank 0, odd in bank 1: the two writes of a pixel never share a bank
    assign bank_raddr = sedh_pkg::bank_addr_t'(pos.c >> 1);

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            bank_we[j]    = 1'b0;
            bank_waddr[j] = sedh_pkg::bank_addr_t'(b_pos_reg.c >> 1);
            bank_wdata[j] = here_word;
            if (clr_busy_reg)
            begin
                bank_we[j]    = 1'b1;
                bank_waddr[j] = clr_idx_reg;
                bank_wdata[j] = '0;
            end
            else if (b_fire && (b_pos_reg.c[0] == 1'(j)))
            begin
                bank_we[j] = 1'b1;
            end
            else if (b_fire && behind_en && (b_pos_reg.behind[0] == 1'(j)))
            begin
                bank_we[j]    = 1'b1;
                bank_waddr[j] = sedh_pkg::bank_addr_t'(b_pos_reg.behind >> 1);
                bank_wdata[j] = behind_word;
            end
        end
    end

    for (genvar j = 0; j < 2; j++)
    begin : g_bank
        sedh_ram #(
            .WIDTH (sedh_pkg::LINE_BITS),
            .DEPTH (sedh_pkg::BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[j]),
            .waddr (bank_waddr[j]),
            .wdata (bank_wdata[j]),
            .re    (accept),
            .raddr (bank_raddr),
            .rdata (bank_rdata[j])
        );
    end

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_idx_next  = clr_idx_reg;
        if (clr_busy_reg)
        begin
            if (clr_idx_reg == sedh_pkg::bank_addr_t'(sedh_pkg::BANK_DEPTH - 1))
                clr_busy_next = 1'b0;
            else
                clr_idx_next = clr_idx_reg + sedh_pkg::bank_addr_t'(1);
        end
    end

    // bypass a write that lands in the same cycle as the read of its entry
    always_comb
    begin
        fwd_hit_next  = fwd_hit_reg;
        fwd_word_next = fwd_word_reg;
        if (accept)
        begin
            fwd_hit_next  = 1'b0;
            fwd_word_next = here_word;
            if (b_fire && (pos.c == b_pos_reg.c))
            begin
                fwd_hit_next = 1'b1;
            end
            else if (b_fire && behind_en && (pos.c == b_pos_reg.behind))
            begin
                fwd_hit_next  = 1'b1;
                fwd_word_next = behind_word;
            end
        end
    end

    assign line_word = fwd_hit_reg ? fwd_word_reg
                                   : (b_pos_reg.c[0] ? bank_rdata[1] : bank_rdata[0]);

    // ---------------------------------------------------------------- lanes
    assign lane_ctl.fire     = b_fire;
    assign lane_ctl.last_col = b_pos_reg.last_col;
    assign lane_ctl.last_row = b_pos_reg.last_row;

    for (genvar g = 0; g < sedh_pkg::LANES; g++)
    begin : g_lane
        sedh_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (lane_ctl),
            .sample     (b_sample_reg[g]),
            .threshold  (thr_reg),
            .line_err   (line_word[g*EB +: EB]),
            .on         (lane_on[g]),
            .here_err   (here_word[g*EB +: EB]),
            .behind_err (behind_word[g*EB +: EB])
        );
    end

    // ---------------------------------------------------------------- stage control
    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (accept)
            b_valid_next = 1'b1;
        else if (b_fire)
            b_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (b_fire)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            b_valid_reg   <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            clr_busy_reg  <= clr_busy_next;
            clr_idx_reg   <= clr_idx_next;
            b_valid_reg   <= b_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_word_reg <= fwd_word_next;
        if (accept)
        begin
            b_pos_reg       <= pos;
            b_sample_reg[0] <= pixel.red_in;
            b_sample_reg[1] <= pixel.green_in;
            b_sample_reg[2] <= pixel.blue_in;
        end
        if (b_fire)
        begin
            res_on_reg  <= lane_on;
            res_eor_reg <= b_pos_reg.last_col;
            res_eof_reg <= b_pos_reg.last_col && b_pos_reg.last_row;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.red_on       = res_on_reg[0];
    assign result.green_on     = res_on_reg[1];
    assign result.blue_on      = res_on_reg[2];
    assign result.end_of_row   = res_eor_reg;
    assign result.end_of_frame = res_eof_reg;

    // ---------------------------------------------------------------- assertions
    ap_no_request_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !pixel.ready)
        else $error("pixel request accepted during line clearing pass");

    ap_writes_split_banks: assert property (@(posedge clk) disable iff (!rst_n)
        (b_fire && behind_en) |-> (b_pos_reg.c[0] != b_pos_reg.behind[0]))
        else $error("two line writes aimed at one bank");

    ap_stage_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && res_valid_reg && !result.ready) |=> (b_valid_reg && $stable(b_pos_reg)))
        else $error("compute stage moved while result stalled");

    ap_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_eof_reg) |-> res_eor_reg)
        else $error("end of frame without end of row");

endmodule

// File: rtl/sedh_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sedh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/sedh_scan.sv
`timescale 1ns / 1ps
// Serpentine scan position: column and row counters, clamped image size, line addresses.
// Depends on sedh_pkg.
module sedh_scan (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  logic [sedh_pkg::WIDTH_REG_BITS-1:0]  image_width,
    input  logic [sedh_pkg::HEIGHT_REG_BITS-1:0] image_height,
    output sedh_pkg::pos_t                       pos
);

    sedh_pkg::col_t col_reg;
    sedh_pkg::col_t col_next;
    sedh_pkg::row_t row_reg;
    sedh_pkg::row_t row_next;
    sedh_pkg::col_t w_m1;
    sedh_pkg::row_t h_m1;
    sedh_pkg::col_t k;

    // clamp size into 1..max
    always_comb
    begin
        if (image_width == '0)
            w_m1 = '0;
        else if (int'(image_width) > sedh_pkg::MAX_WIDTH)
            w_m1 = sedh_pkg::COL_BITS'(sedh_pkg::MAX_WIDTH - 1);
        else
            w_m1 = sedh_pkg::COL_BITS'(image_width - 11'd1);

        if (image_height == '0)
            h_m1 = '0;
        else if (int'(image_height) > sedh_pkg::MAX_HEIGHT)
            h_m1 = sedh_pkg::ROW_BITS'(sedh_pkg::MAX_HEIGHT - 1);
        else
            h_m1 = sedh_pkg::ROW_BITS'(image_height - 13'd1);
    end

    always_comb
    begin
        k            = (col_reg > w_m1) ? w_m1 : col_reg;
        pos.c        = row_reg[0] ? (w_m1 - k) : k;
        pos.behind   = row_reg[0] ? (pos.c + sedh_pkg::COL_BITS'(1))
                                  : (pos.c - sedh_pkg::COL_BITS'(1));
        pos.first    = (k == '0);
        pos.last_col = (k == w_m1);
        pos.last_row = (row_reg >= h_m1);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (pos.last_col)
            begin
                col_next = '0;
                row_next = pos.last_row ? '0 : (row_reg + sedh_pkg::ROW_BITS'(1));
            end
            else
            begin
                col_next = k + sedh_pkg::COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: rtl/sedh_lane.sv
`timescale 1ns / 1ps
// One color lane: adjusted value, threshold decision, error split and same-row error state.
// Depends on sedh_pkg (types, sat, share).
module sedh_lane (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sedh_pkg::lane_ctl_t              ctl,
    input  logic [sedh_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [sedh_pkg::THR_BITS-1:0]    threshold,
    input  sedh_pkg::err_t                   line_err,
    output logic                             on,
    output sedh_pkg::err_t                   here_err,
    output sedh_pkg::err_t                   behind_err
);

    sedh_pkg::err_t  ahead_reg;
    sedh_pkg::err_t  ahead_next;
    sedh_pkg::err_t  pend0_reg;
    sedh_pkg::err_t  pend0_next;
    sedh_pkg::err_t  pend1_reg;
    sedh_pkg::err_t  pend1_next;
    sedh_pkg::wide_t sum;
    sedh_pkg::err_t  v;
    sedh_pkg::err_t  e;
    sedh_pkg::err_t  p0;

    always_comb
    begin
        sum = sedh_pkg::wide_t'({sample, 4'b0000}) + sedh_pkg::wide_t'(ahead_reg)
            + sedh_pkg::wide_t'(line_err);
        v   = sedh_pkg::sat(sum);
        on  = sedh_pkg::wide_t'(v) >= sedh_pkg::wide_t'({threshold, 4'b0000});
        e   = on ? sedh_pkg::sat(sedh_pkg::wide_t'(v) - sedh_pkg::wide_t'(sedh_pkg::FULL_ON))
                 : v;

        behind_err = sedh_pkg::sat(sedh_pkg::wide_t'(pend0_reg)
                   + sedh_pkg::wide_t'(sedh_pkg::share(e, sedh_pkg::W_BEHIND)));
        p0         = sedh_pkg::sat(sedh_pkg::wide_t'(pend1_reg)
                   + sedh_pkg::wide_t'(sedh_pkg::share(e, sedh_pkg::W_BELOW)));
        // the row's last column settles its own line entry
        here_err   = (ctl.last_col && !ctl.last_row) ? p0 : '0;
    end

    always_comb
    begin
        ahead_next = ahead_reg;
        pend0_next = pend0_reg;
        pend1_next = pend1_reg;
        if (ctl.fire)
        begin
            if (ctl.last_col)
            begin
                ahead_next = '0;
                pend0_next = '0;
                pend1_next = '0;
            end
            else
            begin
                ahead_next = sedh_pkg::share(e, sedh_pkg::W_AHEAD);
                pend0_next = p0;
                pend1_next = sedh_pkg::share(e, sedh_pkg::W_DIAG);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ahead_reg <= '0;
            pend0_reg <= '0;
            pend1_reg <= '0;
        end
        else
        begin
            ahead_reg <= ahead_next;
            pend0_reg <= pend0_next;
            pend1_reg <= pend1_next;
        end
    end

endmodule
